FILE: hdl/mrnp_pkg.sv
// Package with types, codes and constants of the multiprotocol reach NLRI parser.
package mrnp_pkg;

   localparam int MaxAddrBytes = 16;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_AFI_LO = 4'd1,
      PH_SAFI   = 4'd2,
      PH_NHLEN  = 4'd3,
      PH_NH     = 4'd4,
      PH_RSV    = 4'd5,
      PH_ROUTE  = 4'd6,
      PH_PATH   = 4'd7,
      PH_PLEN   = 4'd8,
      PH_LABEL  = 4'd9,
      PH_RD     = 4'd10,
      PH_ADDR   = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NEXT_HOP  = 3'd0,
      KIND_LABEL     = 3'd1,
      KIND_ROUTE     = 3'd2,
      KIND_UNSUPP    = 3'd3,
      KIND_LEN_ERROR = 3'd4
   } kind_type;

   localparam logic [1:0] RT_UNICAST = 2'd0;
   localparam logic [1:0] RT_LABELED = 2'd1;
   localparam logic [1:0] RT_VPN     = 2'd2;

   localparam logic [15:0] AFI_IPV4 = 16'd1;
   localparam logic [15:0] AFI_IPV6 = 16'd2;
   localparam logic [7:0]  SAFI_UNICAST = 8'd1;
   localparam logic [7:0]  SAFI_LABELED = 8'd4;
   localparam logic [7:0]  SAFI_VPN     = 8'd128;

   // One result record; packed width 260 bits.
   typedef struct packed {
      logic        last_of_run;
      logic        has_distinguisher;
      logic [63:0] distinguisher;
      logic [19:0] label_value;
      logic [63:0] addr_low;
      logic [63:0] addr_high;
      logic [7:0]  prefix_bits;
      logic [31:0] path_id;
      logic [1:0]  route_type;
      logic        family_v6;
      logic [2:0]  kind;
   } rec_type;

endpackage

FILE: hdl/mp_reach_nlri_parser_unit.sv
// Top level of the multiprotocol reach NLRI parser: byte stream in, record stream out.
//
// The req_ channel carries one attribute byte per item in tdata[7:0]; tuser marks
// the first byte of an attribute, whose tdata[23:8] give the attribute length.
// The rsp_ channel carries records (next hop, label, route, unsupported family,
// length error) with kind, family and route type in tuser; each accepted byte
// yields zero, one or two records, the last of which has tlast set.
// A byte is parsed in the cycle it is accepted; its records are registered in a
// two-entry output buffer whose head drives the rsp_ channel. One byte per cycle
// is sustained while the receiver keeps up; a byte that yields two records holds
// off the next byte while both records sit in the buffer.
// A byte is accepted whenever the buffer will have room for two records,
// counting the one leaving in the same cycle.
// When the receiver stalls, records stay put in the buffer and req_tready
// falls once it cannot hold two more.
// Reset empties the buffer, returns the parser to header start and clears
// the add-path mask; csr_ writes load the mask at any clock edge.
module mp_reach_nlri_parser_unit #(
   parameter int MAX_ADDR_BYTES = mrnp_pkg::MaxAddrBytes
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [3:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // data_byte[7:0], attr_length[15:0]
   input  logic         req_tuser,   // first_of_attribute
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // path_id[31:0], prefix_bits[7:0], addr_high[63:0], addr_low[63:0],
   // label_value[19:0], distinguisher[63:0], has_distinguisher, zero fill to 256 bits
   output logic [255:0] rsp_tdata,
   output logic [5:0]   rsp_tuser,   // kind[2:0], family_v6, route_type[1:0]
   output logic         rsp_tlast
);
   import mrnp_pkg::*;

   logic [3:0]  mask_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] fam_ff, fam_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [63:0] ahi_ff, ahi_in, alo_ff, alo_in;
   logic [31:0] pid_ff, pid_in;
   logic [23:0] lab_ff, lab_in;
   logic [63:0] rd_ff, rd_in;
   logic [7:0]  rbits_ff, rbits_in;
   logic [7:0]  rbl_ff, rbl_in;
   logic [7:0]  lbs_ff, lbs_in;
   logic        rdt_ff, rdt_in;

   rec_type     buf_ff [2];
   logic [1:0]  cnt_buf_ff;
   rec_type     r0, r1;
   logic [1:0]  nrec;

   logic        acc, pop;
   logic [7:0]  b;
   logic        first;
   logic [15:0] alen;

   assign b     = req_tdata[7:0];
   assign first = req_tuser;
   assign alen  = req_tdata[23:8];
   assign pop   = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_buf_ff == 2'd0) || (cnt_buf_ff == 2'd1 && pop);
   assign acc   = req_tvalid && req_tready;

   function automatic rec_type simple(input kind_type k);
      rec_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   always_comb begin
      logic        v6;
      logic [1:0]  rt;
      logic        sup;
      phase_type   ph;
      logic [15:0] avail;
      logic        ap;
      logic [1:0]  apbit;
      logic [7:0]  skip;
      logic [7:0]  pos;
      logic [8:0]  lbsum;
      logic [23:0] lsh;
      logic        stop;
      logic [7:0]  rem;
      logic [10:0] sub8;
      logic [7:0]  bits;
      logic        do_route;
      logic [63:0] ah, al;
      rec_type     route;
      v6 = (fam_ff == AFI_IPV6);
      rt = (sub_ff == SAFI_LABELED) ? RT_LABELED :
           (sub_ff == SAFI_VPN) ? RT_VPN : RT_UNICAST;
      sup = ((fam_ff == AFI_IPV4) || (fam_ff == AFI_IPV6)) &&
            ((sub_ff == SAFI_UNICAST) || (sub_ff == SAFI_LABELED) ||
             (sub_ff == SAFI_VPN));
      phase_in = phase_ff; left_in = left_ff; fam_in = fam_ff; sub_in = sub_ff;
      cnt_in = cnt_ff; ahi_in = ahi_ff; alo_in = alo_ff; pid_in = pid_ff;
      lab_in = lab_ff; rd_in = rd_ff; rbits_in = rbits_ff; rbl_in = rbl_ff;
      lbs_in = lbs_ff; rdt_in = rdt_ff;
      r0 = '0; r1 = '0; nrec = 2'd0;
      do_route = 1'b0;
      ph = phase_ff; avail = left_ff; ap = 1'b0; apbit = '0; skip = '0;
      pos = '0; lbsum = '0; lsh = '0; stop = 1'b0; rem = '0; sub8 = '0;
      bits = '0; ah = '0; al = '0; route = '0;

      if (first) begin
         fam_in = '0; sub_in = '0;
         ahi_in = '0; alo_in = '0; pid_in = '0; lab_in = '0; rd_in = '0;
         rbits_in = '0; rbl_in = '0; lbs_in = '0; cnt_in = '0; rdt_in = 1'b0;
         if (alen < 16'd5) begin
            r0 = simple(KIND_LEN_ERROR); nrec = 2'd1;
            phase_in = PH_IDLE; left_in = '0;
         end else begin
            fam_in = {b, 8'd0};
            left_in = alen - 16'd1;
            phase_in = PH_AFI_LO;
         end
      end else if (phase_ff == PH_IDLE || left_ff == 16'd0) begin
         phase_in = PH_IDLE;
      end else begin
         left_in = left_ff - 16'd1;
         if (ph == PH_ROUTE) begin
            apbit = {rt == RT_LABELED, v6};
            ap = (rt != RT_VPN) && mask_ff[apbit];
            cnt_in = '0;
            ph = (ap && avail >= 16'd4) ? PH_PATH : PH_PLEN;
         end
         phase_in = ph;
         unique case (ph)
            PH_AFI_LO: begin
               fam_in = {fam_ff[15:8], b}; phase_in = PH_SAFI;
            end
            PH_SAFI: begin
               sub_in = b; phase_in = PH_NHLEN;
            end
            PH_NHLEN: begin
               cnt_in = '0; rbl_in = b;
               if ({1'b0, left_in} < {9'd0, b} + 17'd1) begin
                  r0 = simple(KIND_LEN_ERROR); nrec = 2'd1;
                  phase_in = PH_IDLE; left_in = '0;
               end else if (!sup) begin
                  r0 = simple(KIND_UNSUPP); nrec = 2'd1;
                  phase_in = PH_IDLE; left_in = '0;
               end else begin
                  phase_in = (b != 8'd0) ? PH_NH : PH_RSV;
               end
            end
            PH_NH: begin
               skip = (!v6 && rt == RT_VPN) ? 8'd8 : 8'd0;
               pos = cnt_ff - skip;
               if (cnt_ff >= skip && pos < 8'(MAX_ADDR_BYTES)) begin
                  if (pos[7:3] == 5'd0)
                     ahi_in[8*(7-pos[2:0]) +: 8] = b;
                  else
                     alo_in[8*(7-pos[2:0]) +: 8] = b;
               end
               cnt_in = cnt_ff + 8'd1;
               if (cnt_in >= rbl_ff) phase_in = PH_RSV;
            end
            PH_RSV: begin
               r0 = '0; r0.kind = KIND_NEXT_HOP; r0.family_v6 = v6;
               r0.route_type = rt; r0.addr_high = ahi_ff; r0.addr_low = alo_ff;
               nrec = 2'd1;
               ahi_in = '0; alo_in = '0; pid_in = '0; lab_in = '0; rd_in = '0;
               rbits_in = '0; rbl_in = '0; lbs_in = '0; cnt_in = '0;
               rdt_in = 1'b0;
               phase_in = PH_ROUTE;
            end
            PH_PATH: begin
               pid_in = {pid_ff[23:0], b};
               cnt_in = cnt_ff + 8'd1;
               if (cnt_in >= 8'd4) begin
                  cnt_in = '0; phase_in = PH_PLEN;
               end
            end
            PH_PLEN: begin
               rbits_in = b;
               rbl_in = 8'(({1'b0, b} + 9'd7) >> 3);
               cnt_in = '0;
               if (rt != RT_UNICAST) begin
                  lbs_in = '0; lab_in = '0; phase_in = PH_LABEL;
               end else if (rbl_in == 8'd0) begin
                  do_route = 1'b1;
               end else begin
                  phase_in = PH_ADDR;
               end
            end
            PH_LABEL: begin
               lsh = {lab_ff[15:0], b};
               lab_in = lsh;
               cnt_in = cnt_ff + 8'd1;
               if (cnt_in >= 8'd3) begin
                  cnt_in = '0;
                  lbsum = {1'b0, lbs_ff} + 9'd3;
                  lbs_in = lbsum[7:0];
                  r0 = '0; r0.kind = KIND_LABEL; r0.family_v6 = v6;
                  r0.route_type = rt; r0.label_value = lsh[23:4];
                  nrec = 2'd1;
                  stop = lsh[0] || lsh == 24'h800000 || lsh == 24'd0 ||
                         lbs_in > rbl_ff;
                  if (stop) begin
                     rem = (rbl_ff > lbs_in) ? rbl_ff - lbs_in : 8'd0;
                     sub8 = {lbs_in, 3'b000};
                     bits = ({3'd0, rbits_ff} > sub8) ?
                            8'({3'd0, rbits_ff} - sub8) : 8'd0;
                     if (rt == RT_VPN && rem >= 8'd8) begin
                        rbits_in = (bits > 8'd64) ? bits - 8'd64 : 8'd0;
                        rdt_in = 1'b1;
                        rbl_in = rem - 8'd8;
                        phase_in = PH_RD;
                     end else if (rem > 8'd0) begin
                        rbits_in = bits; rbl_in = rem; phase_in = PH_ADDR;
                     end else begin
                        rbits_in = bits; do_route = 1'b1;
                     end
                  end else begin
                     lab_in = '0;
                  end
               end
            end
            PH_RD: begin
               rd_in = {rd_ff[55:0], b};
               cnt_in = cnt_ff + 8'd1;
               if (cnt_in >= 8'd8) begin
                  cnt_in = '0;
                  if (rbl_ff > 8'd0) phase_in = PH_ADDR;
                  else do_route = 1'b1;
               end
            end
            PH_ADDR: begin
               if (cnt_ff < 8'(MAX_ADDR_BYTES)) begin
                  if (cnt_ff[7:3] == 5'd0)
                     ahi_in[8*(7-cnt_ff[2:0]) +: 8] = b;
                  else
                     alo_in[8*(7-cnt_ff[2:0]) +: 8] = b;
               end
               cnt_in = cnt_ff + 8'd1;
               if (rbl_ff > 8'd0) rbl_in = rbl_ff - 8'd1;
               if (rbl_in == 8'd0) do_route = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE; left_in = '0;
            end
         endcase

         if (do_route) begin
            route = '0; route.kind = KIND_ROUTE; route.family_v6 = v6;
            route.route_type = rt; route.path_id = pid_in;
            route.prefix_bits = rbits_in; route.addr_high = ahi_in;
            route.addr_low = alo_in;
            route.distinguisher = rdt_in ? rd_in : 64'd0;
            route.has_distinguisher = rdt_in;
            if (nrec == 2'd0) r0 = route; else r1 = route;
            nrec = nrec + 2'd1;
            ahi_in = '0; alo_in = '0; pid_in = '0; lab_in = '0; rd_in = '0;
            rbits_in = '0; rbl_in = '0; lbs_in = '0; cnt_in = '0;
            rdt_in = 1'b0;
            phase_in = PH_ROUTE;
         end

         if (left_in == 16'd0 && phase_in != PH_IDLE) begin
            if (phase_in != PH_ROUTE) begin
               if (nrec == 2'd0) r0 = simple(KIND_LEN_ERROR);
               else r1 = simple(KIND_LEN_ERROR);
               nrec = nrec + 2'd1;
            end
            ahi_in = '0; alo_in = '0; pid_in = '0; lab_in = '0; rd_in = '0;
            rbits_in = '0; rbl_in = '0; lbs_in = '0; cnt_in = '0;
            rdt_in = 1'b0;
            phase_in = PH_IDLE;
         end
      end
      if (nrec == 2'd1) r0.last_of_run = 1'b1;
      if (nrec == 2'd2) r1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wen) begin
         mask_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; left_ff <= '0; fam_ff <= '0; sub_ff <= '0;
         cnt_ff <= '0; ahi_ff <= '0; alo_ff <= '0; pid_ff <= '0; lab_ff <= '0;
         rd_ff <= '0; rbits_ff <= '0; rbl_ff <= '0; lbs_ff <= '0;
         rdt_ff <= 1'b0;
      end else if (acc) begin
         phase_ff <= phase_in; left_ff <= left_in; fam_ff <= fam_in;
         sub_ff <= sub_in; cnt_ff <= cnt_in; ahi_ff <= ahi_in; alo_ff <= alo_in;
         pid_ff <= pid_in; lab_ff <= lab_in; rd_ff <= rd_in;
         rbits_ff <= rbits_in; rbl_ff <= rbl_in; lbs_ff <= lbs_in;
         rdt_ff <= rdt_in;
      end
   end

   // Two-entry output buffer; entry 0 is the head.
   always_ff @(posedge clock) begin
      logic [1:0] keep;
      rec_type    n0, n1;
      keep = cnt_buf_ff - {1'b0, pop};
      n0 = pop ? buf_ff[1] : buf_ff[0];
      n1 = buf_ff[1];
      if (keep == 2'd0) begin
         if (acc && nrec != 2'd0) n0 = r0;
         if (acc) n1 = r1;
      end else if (keep == 2'd1 && acc && nrec != 2'd0) begin
         n1 = r0;
      end
      if (reset) begin
         cnt_buf_ff <= '0;
      end else begin
         cnt_buf_ff <= keep + (acc ? nrec : 2'd0);
      end
      buf_ff[0] <= n0;
      buf_ff[1] <= n1;
   end

   assign rsp_tvalid = (cnt_buf_ff != 2'd0);
   assign rsp_tlast  = buf_ff[0].last_of_run;
   assign rsp_tuser  = {buf_ff[0].route_type, buf_ff[0].family_v6, buf_ff[0].kind};
   assign rsp_tdata  = {3'd0, buf_ff[0].has_distinguisher, buf_ff[0].distinguisher,
                        buf_ff[0].label_value, buf_ff[0].addr_low,
                        buf_ff[0].addr_high, buf_ff[0].prefix_bits,
                        buf_ff[0].path_id};

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_buf_ff != 2'd3) else $error("output buffer overfilled");
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_buf_ff == 2'd2) |-> !req_tready) else $error("accept while full");
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      (acc && nrec == 2'd2) |=> rsp_tvalid) else $error("lost record pair");
endmodule

FILE: bench/tb.sv
// Testbench for the multiprotocol reach NLRI parser: directed and random attributes.
`timescale 1ns / 1ps

module tb;
   import mrnp_pkg::*;

   localparam int IdleLimit = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wen = 1'b0;
   logic [3:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic [5:0]   rsp_tuser;
   logic         rsp_tlast;

   mp_reach_nlri_parser_unit i_dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // Parser model state.
   logic [3:0]  mask_q;
   phase_type   ph;
   logic [15:0] left_q;
   logic [15:0] afi_q;
   logic [7:0]  safi_q;
   int unsigned cnt_q;
   logic [63:0] addr_q [2];
   logic [31:0] pid_q;
   logic [23:0] lab_q;
   logic [63:0] rd_q;
   int unsigned bits_q;
   int unsigned rbl_q;
   int unsigned lseen_q;
   logic        rd_got;

   rec_type     expected_recs[$];
   int          mismatches = 0;
   int          records_seen = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   logic        timed_out = 1'b0;

   function automatic logic fam6();
      return afi_q == AFI_IPV6;
   endfunction

   function automatic logic [1:0] rtyp();
      if (safi_q == SAFI_LABELED) return RT_LABELED;
      if (safi_q == SAFI_VPN) return RT_VPN;
      return RT_UNICAST;
   endfunction

   task automatic put_addr_byte(input int unsigned p, input logic [7:0] b);
      if (p >= 16) return;
      if (p < 8) addr_q[0] = addr_q[0] | (64'(b) << (56 - 8 * p));
      else addr_q[1] = addr_q[1] | (64'(b) << (56 - 8 * (p - 8)));
   endtask

   task automatic clear_route();
      addr_q[0] = '0; addr_q[1] = '0; pid_q = '0; lab_q = '0; rd_q = '0;
      bits_q = 0; rbl_q = 0; lseen_q = 0; cnt_q = 0; rd_got = 1'b0;
   endtask

   task automatic push_simple(input kind_type k, inout rec_type rl[$]);
      rec_type r;
      r = '0;
      r.kind = k;
      rl = {rl, r};
   endtask

   task automatic push_route(inout rec_type rl[$]);
      rec_type r;
      r = '0;
      r.kind = KIND_ROUTE; r.family_v6 = fam6(); r.route_type = rtyp();
      r.path_id = pid_q; r.prefix_bits = bits_q[7:0];
      r.addr_high = addr_q[0]; r.addr_low = addr_q[1];
      r.distinguisher = rd_got ? rd_q : '0; r.has_distinguisher = rd_got;
      rl = {rl, r};
      clear_route();
      ph = PH_ROUTE;
   endtask

   task automatic model_reset();
      mask_q = '0; ph = PH_IDLE; left_q = '0; afi_q = '0; safi_q = '0;
      clear_route();
   endtask

   // Works out the records one byte causes and queues them.
   task automatic predict_byte(input logic [7:0] b, input logic first,
                               input logic [15:0] alen);
      rec_type rl[$];
      int unsigned avail, bitn, skip, rem, lb;
      logic ap, stop;
      if (first) begin
         afi_q = '0; safi_q = '0;
         clear_route();
         if (alen < 5) begin
            push_simple(KIND_LEN_ERROR, rl);
            ph = PH_IDLE; left_q = '0;
         end else begin
            afi_q = {b, 8'h00};
            left_q = alen - 16'd1;
            ph = PH_AFI_LO;
         end
      end else if (ph == PH_IDLE || left_q == 0) begin
         ph = PH_IDLE;
      end else begin
         avail = left_q;
         left_q = left_q - 16'd1;
         if (ph == PH_ROUTE) begin
            bitn = (rtyp() == RT_LABELED ? 2 : 0) + fam6();
            ap = rtyp() != RT_VPN && mask_q[bitn];
            cnt_q = 0;
            ph = (ap && avail >= 4) ? PH_PATH : PH_PLEN;
         end
         case (ph)
            PH_AFI_LO: begin
               afi_q[7:0] = b; ph = PH_SAFI;
            end
            PH_SAFI: begin
               safi_q = b; ph = PH_NHLEN;
            end
            PH_NHLEN: begin
               cnt_q = 0; rbl_q = b;
               if (int'(left_q) < int'(b) + 1) begin
                  push_simple(KIND_LEN_ERROR, rl);
                  ph = PH_IDLE; left_q = '0;
               end else if (!((afi_q == AFI_IPV4 || afi_q == AFI_IPV6) &&
                              (safi_q == SAFI_UNICAST || safi_q == SAFI_LABELED ||
                               safi_q == SAFI_VPN))) begin
                  push_simple(KIND_UNSUPP, rl);
                  ph = PH_IDLE; left_q = '0;
               end else begin
                  ph = (b != 0) ? PH_NH : PH_RSV;
               end
            end
            PH_NH: begin
               // An IPv4 VPN next hop starts with an eight-byte distinguisher.
               skip = (!fam6() && rtyp() == RT_VPN) ? 8 : 0;
               if (cnt_q >= skip) put_addr_byte(cnt_q - skip, b);
               cnt_q++;
               if (cnt_q >= rbl_q) ph = PH_RSV;
            end
            PH_RSV: begin
               rec_type r;
               r = '0;
               r.kind = KIND_NEXT_HOP; r.family_v6 = fam6(); r.route_type = rtyp();
               r.addr_high = addr_q[0]; r.addr_low = addr_q[1];
               rl = {rl, r};
               clear_route();
               ph = PH_ROUTE;
            end
            PH_PATH: begin
               pid_q = {pid_q[23:0], b};
               cnt_q++;
               if (cnt_q >= 4) begin
                  cnt_q = 0; ph = PH_PLEN;
               end
            end
            PH_PLEN: begin
               bits_q = b;
               rbl_q = (int'(b) + 7) >> 3;
               cnt_q = 0;
               if (rtyp() != RT_UNICAST) begin
                  lseen_q = 0; lab_q = '0; ph = PH_LABEL;
               end else if (rbl_q == 0) begin
                  push_route(rl);
               end else begin
                  ph = PH_ADDR;
               end
            end
            PH_LABEL: begin
               lab_q = {lab_q[15:0], b};
               cnt_q++;
               if (cnt_q >= 3) begin
                  rec_type r;
                  cnt_q = 0;
                  lseen_q += 3;
                  r = '0;
                  r.kind = KIND_LABEL; r.family_v6 = fam6(); r.route_type = rtyp();
                  r.label_value = lab_q[23:4];
                  rl = {rl, r};
                  stop = lab_q[0] || lab_q == 24'h800000 || lab_q == 24'h0 ||
                         lseen_q > rbl_q;
                  if (stop) begin
                     lb = lseen_q;
                     rem = rbl_q > lb ? rbl_q - lb : 0;
                     bits_q = bits_q > 8 * lb ? bits_q - 8 * lb : 0;
                     if (rtyp() == RT_VPN && rem >= 8) begin
                        rem -= 8;
                        bits_q = bits_q > 64 ? bits_q - 64 : 0;
                        rd_got = 1'b1; rbl_q = rem; ph = PH_RD;
                     end else if (rem > 0) begin
                        rbl_q = rem; ph = PH_ADDR;
                     end else begin
                        push_route(rl);
                     end
                  end else begin
                     lab_q = '0;
                  end
               end
            end
            PH_RD: begin
               rd_q = {rd_q[55:0], b};
               cnt_q++;
               if (cnt_q >= 8) begin
                  cnt_q = 0;
                  if (rbl_q > 0) ph = PH_ADDR;
                  else push_route(rl);
               end
            end
            PH_ADDR: begin
               put_addr_byte(cnt_q, b);
               cnt_q++;
               if (rbl_q > 0) rbl_q--;
               if (rbl_q == 0) push_route(rl);
            end
            default: begin
               ph = PH_IDLE; left_q = '0;
            end
         endcase
         if (left_q == 0 && ph != PH_IDLE) begin
            if (ph != PH_ROUTE) push_simple(KIND_LEN_ERROR, rl);
            clear_route();
            ph = PH_IDLE;
         end
      end
      if (rl.size() > 0) rl[rl.size() - 1].last_of_run = 1'b1;
      expected_recs = {expected_recs, rl};
   endtask

   // Sends one byte; the prediction is made at the accepting edge.
   task automatic send_byte(input logic [7:0] b, input logic first,
                            input logic [15:0] alen);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {alen, b};
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, first, alen);
      bytes_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_recs.size() > 0 && !timed_out) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mask(input logic [3:0] m);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen <= 1'b0;
      mask_q = m;
   endtask

   // Builds one attribute from the family, next hop length, route count and mask.
   task automatic build_attr(output logic [7:0] a[$], input logic [15:0] afi,
                             input logic [7:0] safi, input int nhlen,
                             input int nroutes, input logic [3:0] mask);
      int bitn, plen, nb, nl, k;
      logic [1:0] rt;
      a.delete();
      a = {a, afi[15:8], afi[7:0], safi, 8'(nhlen)};
      repeat (nhlen) a = {a, 8'($urandom)};
      a = {a, 8'($urandom)};
      rt = safi == SAFI_LABELED ? RT_LABELED : safi == SAFI_VPN ? RT_VPN : RT_UNICAST;
      bitn = (rt == RT_LABELED ? 2 : 0) + (afi == AFI_IPV6);
      for (int r = 0; r < nroutes; r++) begin
         if (rt != RT_VPN && mask[bitn]) repeat (4) a = {a, 8'($urandom)};
         nl = (rt == RT_UNICAST) ? 0 : $urandom_range(1, 3);
         nb = $urandom_range(0, afi == AFI_IPV6 ? 17 : 5);
         if (rt == RT_VPN) nb += 8;
         plen = 8 * (nb + 3 * nl) - $urandom_range(0, 7);
         if (plen < 0) plen = 0;
         if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 255);
         a = {a, 8'(plen)};
         for (k = 0; k < nl; k++) begin
            a = {a, 8'($urandom), 8'($urandom)};
            a = {a, (k == nl - 1 ? 8'($urandom | 1) : 8'($urandom & 8'hFE))};
         end
         repeat (nb) a = {a, 8'($urandom)};
      end
   endtask

   task automatic send_attr(input logic [7:0] a[$], input int len);
      for (int i = 0; i < a.size(); i++) send_byte(a[i], i == 0, 16'(len));
   endtask

   task automatic test_directed();
      logic [7:0] a[$];
      send_byte(8'hFF, 1'b1, 16'd4);           // attribute too short
      send_byte(8'h00, 1'b0, 16'd0);           // stray byte
      send_byte(8'h00, 1'b1, 16'd0);
      a = {8'h00, 8'h01, 8'h01, 8'h20, 8'h01};  // next hop longer than attribute
      send_attr(a, 5);
      a = {8'h00, 8'h03, 8'h01, 8'h00, 8'h00};  // unknown family
      send_attr(a, 5);
      a = {8'h00, 8'h01, 8'h01, 8'h04, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00,
           8'h00, 8'h18, 8'hC0, 8'hA8};        // cut short inside a route
      send_attr(a, 13);
      a = {8'h00, 8'h02, 8'h01, 8'h00, 8'h00};  // empty next hop, no routes
      send_attr(a, 5);
   endtask

   task automatic test_families(input int count);
      logic [7:0] a[$];
      logic [15:0] afi;
      logic [7:0] safi;
      int len, sel, nh;
      for (int n = 0; n < count; n++) begin
         afi = $urandom_range(0, 1) ? AFI_IPV6 : AFI_IPV4;
         sel = $urandom_range(0, 2);
         safi = sel == 0 ? SAFI_UNICAST : sel == 1 ? SAFI_LABELED : SAFI_VPN;
         nh = $urandom_range(0, 4) == 0 ? $urandom_range(0, 40) :
              (afi == AFI_IPV6 ? 16 : 4) + (safi == SAFI_VPN ? 8 : 0);
         if ($urandom_range(0, 9) == 0) afi = 16'($urandom);
         if ($urandom_range(0, 9) == 0) safi = 8'($urandom);
         build_attr(a, afi, safi, nh, $urandom_range(0, 4), mask_q);
         len = a.size();
         sel = $urandom_range(0, 9);
         if (sel == 0) len = $urandom_range(5, a.size());       // truncated
         else if (sel == 1) repeat ($urandom_range(1, 4)) a = {a, 8'($urandom)};
         else if (sel == 2 && a.size() > 6) a = a[0:$urandom_range(1, a.size() - 2)];
         send_attr(a, len);
      end
   endtask

   task automatic test_noise(input int count);
      for (int n = 0; n < count; n++)
         send_byte(8'($urandom), $urandom_range(0, 7) == 0, 16'($urandom));
      send_byte(8'h00, 1'b1, 16'hFFFF);
      send_byte(8'hFF, 1'b1, 16'hFFFF);
   endtask

   task automatic test_stall_drain();
      drain();
      test_families(3);
   endtask

   // Result checking.
   always @(posedge clock) begin
      rec_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata[252:0], rsp_tuser};
         records_seen++;
         if (expected_recs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected record %h", got);
         end else begin
            exp_r = expected_recs.pop_front();
            if (got !== exp_r || rsp_tdata[255:253] !== 3'h0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("record mismatch: expected %h got %h last %b/%b",
                           exp_r, got, exp_r.last_of_run, rsp_tlast);
            end
         end
      end
   end

   // Receiver stalls.
   initial begin
      int w;
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_mask(4'hF);
      test_families(8);
      write_mask(4'h5);
      test_families(7);
      test_stall_drain();
      write_mask(4'h0);
      test_families(7);
      write_mask(4'hA);
      test_noise(200);
      test_families(3);
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes, checked %0d records over four add-path settings.",
               bytes_sent, records_seen);
      $display("Covered short headers, unknown families, labels, VPN and noise.");
      if (mismatches == 0 && expected_recs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d missing", mismatches, expected_recs.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: mp_reach_nlri_parser_unit.f
hdl/mrnp_pkg.sv
hdl/mp_reach_nlri_parser_unit.sv
bench/tb.sv
